// ===== design/aba_pkg.sv =====
// aba_pkg: shared types, codes and constants for the aligned bump region allocator.
// Depends on nothing; every other design file but aba_ram refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package aba_pkg;

  localparam int MAX_REGIONS_DEF = 64;

  localparam int SIZE_W   = 6;   // log2 size field
  localparam int OFF_W    = 33;  // internal offset width
  localparam int EXT_W    = 35;  // room for aligned offset plus object size
  localparam int OBJ_W    = 32;  // reported object offset
  localparam int RIDX_W   = 6;   // reported region index
  localparam int STATUS_W = 2;

  localparam logic [SIZE_W-1:0] LOG_MAX = 6'd32;

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_ALLOC = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO_SIZE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_FIT    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic              cmd;
    logic [SIZE_W-1:0] size_log2;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [RIDX_W-1:0]   region_index;
    logic [OBJ_W-1:0]    object_offset;
  } out_item_t;

  // one table entry as held in the region RAM
  typedef struct packed {
    logic [SIZE_W-1:0] log_size;
    logic [OFF_W-1:0]  used_offset;
  } entry_t;

  // fit check result for one entry
  typedef struct packed {
    logic             fits;
    logic [OBJ_W-1:0] aligned;
    logic [OFF_W-1:0] waste;
    logic [OFF_W-1:0] end_off;
  } fit_t;

endpackage

`default_nettype wire

// ===== design/aba_ram.sv =====
// aba_ram: generic single-write, single-read RAM with registered read data.
// Standalone; used for the region table.
`timescale 1ns / 1ps
`default_nettype none

module aba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic                                     re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/aba_fit.sv =====
// aba_fit: alignment, fit and waste check of one table entry for one object size.
// Depends on aba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aba_fit (
  input  wire aba_pkg::entry_t               entry,
  input  wire logic [aba_pkg::SIZE_W-1:0]    obj_bits,
  output aba_pkg::fit_t                      fit
);

  logic [aba_pkg::EXT_W-1:0] obj_size;
  logic [aba_pkg::EXT_W-1:0] mask;
  logic [aba_pkg::EXT_W-1:0] off_ext;
  logic [aba_pkg::EXT_W-1:0] aligned;
  logic [aba_pkg::EXT_W-1:0] end_ext;
  logic [aba_pkg::EXT_W-1:0] limit;
  logic [aba_pkg::EXT_W-1:0] waste_ext;

  always_comb begin
    obj_size  = aba_pkg::EXT_W'(1) << obj_bits;
    mask      = obj_size - aba_pkg::EXT_W'(1);
    off_ext   = aba_pkg::EXT_W'(entry.used_offset);
    aligned   = (off_ext + mask) & ~mask;
    end_ext   = aligned + obj_size;
    limit     = aba_pkg::EXT_W'(1) << entry.log_size;
    waste_ext = aligned - off_ext;

    fit.fits    = (end_ext <= limit);
    fit.aligned = aligned[aba_pkg::OBJ_W-1:0];
    fit.waste   = waste_ext[aba_pkg::OFF_W-1:0];
    fit.end_off = end_ext[aba_pkg::OFF_W-1:0];
  end

endmodule

`default_nettype wire

// ===== design/aligned_bump_region_allocator_core.sv =====
// aligned_bump_region_allocator_core: top level, command sequencer around the region RAM.
// Depends on aba_pkg, aba_ram and aba_fit.
//
//   channel  ports                         handshake
//   -------  ----------------------------  ---------------------------------
//   in       start, busy, in_item          beat taken when start && !busy
//   out      out_valid, out_item           one-cycle strobe, no back-pressure
//
// Add: never raises busy; the result shows in the next cycle.
// Alloc: scans the table once from entry 0, one RAM read per entry, through the
//   equal-size run after the first fit, then writes back the chosen entry.
//   Rejected allocs (zero size, oversized, empty table) answer in the next cycle.
// Reset clears the region count, the sequencer and the result strobe; table contents
//   are not cleared, entries at or above the count are never read.
// The receiver cannot stall: each result is a single-cycle strobe.
`timescale 1ns / 1ps
`default_nettype none

module aligned_bump_region_allocator_core #(
  parameter int MAX_REGIONS = aba_pkg::MAX_REGIONS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire aba_pkg::in_item_t  in_item,
  output logic                    out_valid,
  output aba_pkg::out_item_t      out_item
);

  localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CNT_W = $clog2(MAX_REGIONS + 1);
  localparam int ENT_W = $bits(aba_pkg::entry_t);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;  // waiting for a command
  localparam logic [1:0] S_FIND = 2'd1;  // first-fit search
  localparam logic [1:0] S_RUN  = 2'd2;  // least-waste pick among same-size run
  localparam logic [1:0] S_BUMP = 2'd3;  // write back bumped offset

  logic [1:0]                  state_r, state_nxt;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic [IDX_W-1:0]            cur_idx_r, cur_idx_nxt;
  logic [aba_pkg::SIZE_W-1:0]  req_bits_r, req_bits_nxt;
  logic [IDX_W-1:0]            best_idx_r, best_idx_nxt;
  logic [aba_pkg::SIZE_W-1:0]  best_log_r, best_log_nxt;
  logic [aba_pkg::OFF_W-1:0]   best_waste_r, best_waste_nxt;
  logic [aba_pkg::OBJ_W-1:0]   best_aligned_r, best_aligned_nxt;
  logic [aba_pkg::OFF_W-1:0]   best_end_r, best_end_nxt;
  logic                        out_valid_r, out_valid_nxt;
  aba_pkg::out_item_t          out_item_r, out_item_nxt;

  // RAM port controls
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  aba_pkg::entry_t      ram_wentry;
  logic                 ram_re;
  logic [IDX_W-1:0]     ram_raddr;
  logic [ENT_W-1:0]     ram_rdata;
  aba_pkg::entry_t      rd_entry;
  aba_pkg::fit_t        fit;

  logic                 accept;
  logic                 table_full;
  logic [CNT_W-1:0]     next_idx_ext;
  logic                 more;
  logic [IDX_W+5:0]     count_idx_ext;
  logic [IDX_W+5:0]     best_idx_ext;

  assign rd_entry = aba_pkg::entry_t'(ram_rdata);

  aba_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_REGIONS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wentry),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // fit check on the entry read in the previous cycle
  aba_fit u_fit (
    .entry    (rd_entry),
    .obj_bits (req_bits_r),
    .fit      (fit)
  );

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign table_full   = (count_r == CNT_W'(MAX_REGIONS));
  assign next_idx_ext = CNT_W'(cur_idx_r) + CNT_W'(1);
  assign more         = (next_idx_ext < count_r);

  // reported index is the low six bits of the region number
  assign count_idx_ext = {6'd0, count_r[IDX_W-1:0]};
  assign best_idx_ext  = {6'd0, best_idx_r};

  // Only one command is in flight, so a write-back always lands before the
  // next scan reads the table: no forwarding needed.
  always_comb begin
    state_nxt        = state_r;
    count_nxt        = count_r;
    cur_idx_nxt      = cur_idx_r;
    req_bits_nxt     = req_bits_r;
    best_idx_nxt     = best_idx_r;
    best_log_nxt     = best_log_r;
    best_waste_nxt   = best_waste_r;
    best_aligned_nxt = best_aligned_r;
    best_end_nxt     = best_end_r;
    out_valid_nxt    = 1'b0;
    out_item_nxt     = out_item_r;

    ram_we                 = 1'b0;
    ram_waddr              = count_r[IDX_W-1:0];
    ram_wentry.log_size    = best_log_r;
    ram_wentry.used_offset = best_end_r;
    ram_re                 = 1'b0;
    ram_raddr              = next_idx_ext[IDX_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_item_nxt.status        = aba_pkg::ST_OK;
          out_item_nxt.region_index  = '0;
          out_item_nxt.object_offset = '0;
          if (in_item.cmd == aba_pkg::CMD_ADD) begin
            out_valid_nxt = 1'b1;
            if (table_full) begin
              out_item_nxt.status = aba_pkg::ST_FULL;
            end else begin
              // append region; oversized requests saturate at 2^32 bytes
              ram_we                 = 1'b1;
              ram_waddr              = count_r[IDX_W-1:0];
              ram_wentry.log_size    = (in_item.size_log2 > aba_pkg::LOG_MAX) ?
                                       aba_pkg::LOG_MAX : in_item.size_log2;
              ram_wentry.used_offset = '0;
              count_nxt              = count_r + CNT_W'(1);
              out_item_nxt.region_index = count_idx_ext[5:0];
            end
          end else if (in_item.size_log2 == '0) begin
            out_valid_nxt       = 1'b1;
            out_item_nxt.status = aba_pkg::ST_ZERO_SIZE;
          end else if (in_item.size_log2 > aba_pkg::LOG_MAX || count_r == '0) begin
            out_valid_nxt       = 1'b1;
            out_item_nxt.status = aba_pkg::ST_NO_FIT;
          end else begin
            ram_re       = 1'b1;
            ram_raddr    = '0;
            cur_idx_nxt  = '0;
            req_bits_nxt = in_item.size_log2;
            state_nxt    = S_FIND;
          end
        end
      end

      S_FIND: begin
        if (fit.fits) begin
          best_idx_nxt     = cur_idx_r;
          best_log_nxt     = rd_entry.log_size;
          best_waste_nxt   = fit.waste;
          best_aligned_nxt = fit.aligned;
          best_end_nxt     = fit.end_off;
          state_nxt        = S_BUMP;
          if (more) begin
            ram_re      = 1'b1;
            cur_idx_nxt = next_idx_ext[IDX_W-1:0];
            state_nxt   = S_RUN;
          end
        end else if (more) begin
          ram_re      = 1'b1;
          cur_idx_nxt = next_idx_ext[IDX_W-1:0];
        end else begin
          out_valid_nxt              = 1'b1;
          out_item_nxt.status        = aba_pkg::ST_NO_FIT;
          out_item_nxt.region_index  = '0;
          out_item_nxt.object_offset = '0;
          state_nxt                  = S_IDLE;
        end
      end

      S_RUN: begin
        state_nxt = S_BUMP;
        if (rd_entry.log_size == best_log_r) begin
          // strict compare: earlier region wins a tie
          if (fit.fits && fit.waste < best_waste_r) begin
            best_idx_nxt     = cur_idx_r;
            best_waste_nxt   = fit.waste;
            best_aligned_nxt = fit.aligned;
            best_end_nxt     = fit.end_off;
          end
          if (more) begin
            ram_re      = 1'b1;
            cur_idx_nxt = next_idx_ext[IDX_W-1:0];
            state_nxt   = S_RUN;
          end
        end
      end

      S_BUMP: begin
        ram_we                     = 1'b1;
        ram_waddr                  = best_idx_r;
        ram_wentry.log_size        = best_log_r;
        ram_wentry.used_offset     = best_end_r;
        out_valid_nxt              = 1'b1;
        out_item_nxt.status        = aba_pkg::ST_OK;
        out_item_nxt.region_index  = best_idx_ext[5:0];
        out_item_nxt.object_offset = best_aligned_r;
        state_nxt                  = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_idx_r      <= cur_idx_nxt;
    req_bits_r     <= req_bits_nxt;
    best_idx_r     <= best_idx_nxt;
    best_log_r     <= best_log_nxt;
    best_waste_r   <= best_waste_nxt;
    best_aligned_r <= best_aligned_nxt;
    best_end_r     <= best_end_nxt;
    out_item_r     <= out_item_nxt;
  end

endmodule

`default_nettype wire

// ===== design/aba_checker.sv =====
// aba_checker: port-level assertions for the allocator, bound to the top level.
// Depends on aba_pkg and aligned_bump_region_allocator_core.
`timescale 1ns / 1ps
`default_nettype none

module aba_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire aba_pkg::in_item_t  in_item,
  input wire logic               out_valid,
  input wire aba_pkg::out_item_t out_item
);

  // an add never occupies the block and always answers next cycle
  a_add_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.cmd == aba_pkg::CMD_ADD) |=> (out_valid && !busy))
    else $error("add did not answer in one cycle");

  // zero-size alloc is rejected at once
  a_zero_size: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.cmd == aba_pkg::CMD_ALLOC && in_item.size_log2 == '0)
    |=> (out_valid && out_item.status == aba_pkg::ST_ZERO_SIZE))
    else $error("zero-size alloc not rejected");

  // failed results carry zero fields
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status != aba_pkg::ST_OK)
    |-> (out_item.region_index == '0 && out_item.object_offset == '0))
    else $error("failed result carries nonzero fields");

  // entering a scan never coincides with a result
  a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> !out_valid)
    else $error("result issued while a scan starts");

  // every add, successful or not, reports offset zero
  a_add_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.cmd == aba_pkg::CMD_ADD)
    |=> (out_item.object_offset == '0))
    else $error("add reported nonzero offset");

endmodule

bind aligned_bump_region_allocator_core aba_checker u_aba_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);

`default_nettype wire

// ===== dv/aba_scoreboard_pkg.sv =====
// aba_scoreboard_pkg: scoreboard for the aligned bump region allocator testbench.
// Holds a shadow copy of the region table and predicts every result; depends on aba_pkg.
`timescale 1ns / 1ps

package aba_scoreboard_pkg;

  import aba_pkg::*;

  class bump_alloc_scoreboard;

    // shadow region table
    logic [SIZE_W-1:0] region_log2   [MAX_REGIONS_DEF];
    logic [OFF_W-1:0]  region_offset [MAX_REGIONS_DEF];
    int unsigned       region_total = 0;

    out_item_t   expected_results[$];
    int unsigned mismatches = 0;

    function bit [63:0] round_up(bit [63:0] v, int unsigned bits);
      bit [63:0] mask;
      mask = (64'd1 << bits) - 64'd1;
      if ((v & mask) != 64'd0) return (v & ~mask) + (64'd1 << bits);
      return v;
    endfunction

    function bit fits(int unsigned r, int unsigned bits);
      bit [63:0] limit;
      limit = 64'd1 << region_log2[r];
      return (round_up(region_offset[r], bits) + (64'd1 << bits)) <= limit;
    endfunction

    function bit [63:0] waste(int unsigned r, int unsigned bits);
      return round_up(region_offset[r], bits) - region_offset[r];
    endfunction

    function out_item_t predict_result(in_item_t req);
      int unsigned n;
      int unsigned first;
      int unsigned pick;
      int unsigned j;
      int unsigned bits;
      bit [63:0]   aligned;
      bit [63:0]   bumped;
      out_item_t   res;
      res  = '0;
      n    = region_total;
      bits = req.size_log2;
      if (req.cmd == CMD_ADD) begin
        if (n >= MAX_REGIONS_DEF) begin
          res.status = ST_FULL;
          return res;
        end
        region_log2[n]   = (req.size_log2 > LOG_MAX) ? LOG_MAX : req.size_log2;
        region_offset[n] = '0;
        region_total     = n + 1;
        res.region_index = n[RIDX_W-1:0];
        return res;
      end
      if (bits == 0) begin
        res.status = ST_ZERO_SIZE;
        return res;
      end
      if (bits > LOG_MAX) begin
        res.status = ST_NO_FIT;
        return res;
      end
      first = 0;
      while (first < n && !fits(first, bits)) first++;
      if (first == n) begin
        res.status = ST_NO_FIT;
        return res;
      end
      // least waste within the run of equal-size regions; earlier wins a tie
      pick = first;
      for (j = first; j < n && region_log2[j] == region_log2[first]; j++) begin
        if (fits(j, bits) && waste(j, bits) < waste(pick, bits)) pick = j;
      end
      aligned             = round_up(region_offset[pick], bits);
      bumped              = aligned + (64'd1 << bits);
      region_offset[pick] = bumped[OFF_W-1:0];
      res.region_index    = pick[RIDX_W-1:0];
      res.object_offset   = aligned[OBJ_W-1:0];
      return res;
    endfunction

    function void note_request(in_item_t req);
      expected_results.push_back(predict_result(req));
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with none pending: status %0d index %0d offset %h",
                   $time, got.status, got.region_index, got.object_offset);
        return;
      end
      want = expected_results.pop_front();
      if (got.status !== want.status || got.region_index !== want.region_index ||
          got.object_offset !== want.object_offset) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch: want status %0d index %0d offset %h, got %0d %0d %h",
                   $time, want.status, want.region_index, want.object_offset,
                   got.status, got.region_index, got.object_offset);
      end
    endfunction

    function int unsigned outstanding();
      return expected_results.size();
    endfunction

  endclass

endpackage

// ===== dv/aligned_bump_region_allocator_core_tb.sv =====
// aligned_bump_region_allocator_core_tb: self-checking bench for the allocator core.
// Directed corner beats, then random add/alloc traffic; needs aba_pkg and aba_scoreboard_pkg.
`timescale 1ns / 1ps

module aligned_bump_region_allocator_core_tb;

  import aba_pkg::*;
  import aba_scoreboard_pkg::*;

  localparam int RANDOM_BEATS = 1130;
  localparam int DRAIN_AT     = 560;     // sender waits for an empty pipe here
  localparam int TAIL_CYCLES  = 80;      // longer than the longest alloc scan
  localparam int CYCLE_LIMIT  = 500000;

  logic      clk     = 1'b0;
  logic      rst_n   = 1'b0;
  logic      start   = 1'b0;
  in_item_t  in_item = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_item;

  bump_alloc_scoreboard sb;

  int unsigned cycle_count = 0;
  bit          idle_on     = 1'b1;  // cleared for stretches of back-to-back beats
  int unsigned run_log2    = 8;     // region size shared by a run of adds
  int unsigned run_left    = 0;

  aligned_bump_region_allocator_core #(
    .MAX_REGIONS(MAX_REGIONS_DEF)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: any hang ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Monitor. Both channels are sampled at the edge that takes the beat, so the
  // values seen here are the pre-edge ones. A result never appears in the
  // same cycle its request is taken, so checking first is safe.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_result(out_item);
      if (start && !busy) sb.note_request(in_item);
    end
  end

  function automatic in_item_t make_req(logic cmd, int unsigned bits);
    in_item_t req;
    req           = '0;
    req.cmd       = cmd;
    req.size_log2 = bits[SIZE_W-1:0];
    return req;
  endfunction

  // Called just after the clock rises. Optional idle gap, then hold start high
  // until an edge finds busy low. A zero gap keeps start high across beats
  // so start only ever gets one nonblocking write per time step.
  task automatic send_beat(in_item_t req);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= req;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // Pause the sender until every pending result is back.
  task automatic wait_all_results();
    start <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  // Random traffic. Adds are rare (about one in fourteen) so the table fills
  // past the middle of the run and later adds hit the full table. Adds come
  // in runs of equal size so the least-waste pick among neighbors gets
  // exercised; alloc sizes are mostly small so regions last and offsets end
  // up misaligned against larger requests.
  function automatic in_item_t random_request();
    int unsigned pick;
    int unsigned bits;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 13) == 0) begin
      if (run_left == 0) begin
        if (pick < 70)      run_log2 = $urandom_range(6, 16);
        else if (pick < 85) run_log2 = $urandom_range(17, 32);
        else if (pick < 95) run_log2 = $urandom_range(0, 5);
        else                run_log2 = $urandom_range(33, 63);
        run_left = $urandom_range(1, 4);
      end
      run_left--;
      return make_req(CMD_ADD, run_log2);
    end
    if (pick < 55)      bits = $urandom_range(1, 4);
    else if (pick < 80) bits = $urandom_range(5, 12);
    else if (pick < 88) bits = $urandom_range(13, 32);
    else if (pick < 94) bits = 0;
    else                bits = $urandom_range(33, 63);
    return make_req(CMD_ALLOC, bits);
  endfunction

  initial begin
    int k;
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: rejects on an empty table, size clamping, 2^32 regions,
    // the top offset bit, waste-based choice inside equal-size runs.
    send_beat(make_req(CMD_ALLOC, 5));   // empty table, no fit
    send_beat(make_req(CMD_ALLOC, 0));   // zero object size
    send_beat(make_req(CMD_ALLOC, 63));  // oversized object
    send_beat(make_req(CMD_ADD,   0));   // one-byte region
    send_beat(make_req(CMD_ADD,   63));  // clamps to 2^32
    send_beat(make_req(CMD_ADD,   40));  // clamps to 2^32
    send_beat(make_req(CMD_ADD,   32));
    send_beat(make_req(CMD_ALLOC, 1));   // skips the one-byte region
    send_beat(make_req(CMD_ALLOC, 33));  // oversized, table not empty
    send_beat(make_req(CMD_ALLOC, 32));  // fills a whole 2^32 region
    send_beat(make_req(CMD_ALLOC, 3));   // later region in run wastes less
    send_beat(make_req(CMD_ALLOC, 31));  // offset 2^31, region ends at 2^32
    send_beat(make_req(CMD_ALLOC, 31));
    send_beat(make_req(CMD_ALLOC, 1));   // everything full, no fit
    send_beat(make_req(CMD_ADD,   4));
    send_beat(make_req(CMD_ADD,   4));
    send_beat(make_req(CMD_ADD,   4));
    send_beat(make_req(CMD_ALLOC, 2));
    send_beat(make_req(CMD_ALLOC, 1));   // tie on waste, first region wins
    send_beat(make_req(CMD_ALLOC, 3));   // misaligned first, clean neighbor wins
    send_beat(make_req(CMD_ALLOC, 4));
    send_beat(make_req(CMD_ADD,   1));

    for (k = 0; k < RANDOM_BEATS; k++) begin
      if (k % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
      if (k == DRAIN_AT) wait_all_results();
      send_beat(random_request());
    end
    start <= 1'b0;

    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    // stray results after the last expected one are still caught here
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.outstanding() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
